FILE: src/assert_macros.svh
// Assertion macros used by the RTL file of the clock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: label");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: label");

`endif

FILE: src/tthc_pkg.sv
`default_nettype none

package tthc_pkg;

   // Request kinds carried in the req_type field.
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } tthc_kind_type;

   // Configuration register indexes.
   localparam logic CSR_COLUMN = 1'b0;
   localparam logic CSR_ROW    = 1'b1;

   // Prescaler values.
   localparam logic [4:0] HALF_SEC_TICK  = 5'd9;
   localparam logic [4:0] FULL_SEC_TICK  = 5'd18;
   localparam logic [4:0] LONG_SEC_START = 5'd30;

   // Hour tens codes.
   localparam logic [1:0] HT_ZERO  = 2'd0;
   localparam logic [1:0] HT_ONE   = 2'd1;
   localparam logic [1:0] HT_BLANK = 2'd2;

   // Character codes.
   localparam logic [5:0] CHAR_SPACE = 6'd32;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;
   localparam logic [5:0] CHAR_ONE   = 6'd49;
   localparam logic [5:0] CHAR_COLON = 6'd58;

   // Positions inside the five-character field.
   localparam logic [2:0] BEAT_FIRST = 3'd0;
   localparam logic [2:0] BEAT_HUNIT = 3'd1;
   localparam logic [2:0] BEAT_COLON = 3'd2;
   localparam logic [2:0] BEAT_MTENS = 3'd3;
   localparam logic [2:0] BEAT_LAST  = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] hour_in;
      logic [5:0] minute_in;
   } tthc_req_type;

   typedef struct packed {
      logic [6:0] char_column;
      logic [5:0] char_row;
      logic [5:0] char_code;
      logic       last_write;
   } tthc_rsp_type;

   // Tens digit of a minute value already limited to 0..59.
   function automatic logic [2:0] minute_tens(input logic [5:0] m);
      logic [2:0] t;
      if (m >= 6'd50) t = 3'd5;
      else if (m >= 6'd40) t = 3'd4;
      else if (m >= 6'd30) t = 3'd3;
      else if (m >= 6'd20) t = 3'd2;
      else if (m >= 6'd10) t = 3'd1;
      else t = 3'd0;
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: src/twelve_hour_tick_clock.sv
// Channel | Ports                         | Moves
// --------+-------------------------------+-------------------------------------
// request | req_valid, req_stall, req_data | tick, start with time, stop
// result  | rsp_valid, rsp_stall, rsp_data | one character write per transfer
// config  | csr_write, csr_index, csr_wdata | screen column and row
//
// A request updates the time at once when it is taken; a new request
// can follow in every cycle while no character burst is pending.
// A tick at the half second yields one write, a tick at the full second five
// writes, one per cycle from the burst register while the receiver does not
// stall; requests stall during a burst until its last write transfers.
// Synchronous reset stops the clock and clears the prescaler, time and config.
// A stalled result holds its character until the receiver takes it.
`default_nettype none

module twelve_hour_tick_clock
   import tthc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire tthc_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output tthc_rsp_type      rsp_data,
   input  wire logic         csr_write,
   input  wire logic         csr_index,
   input  wire logic [6:0]   csr_wdata
);

`include "assert_macros.svh"

   // Configuration.
   logic [6:0] screen_column_ff;
   logic [5:0] screen_row_ff;

   // Time keeping state.
   logic       running_ff, running_in;
   logic [4:0] tick_ff, tick_in;
   logic [3:0] sec_units_ff, sec_units_in;
   logic [2:0] sec_tens_ff, sec_tens_in;
   logic [3:0] min_units_ff, min_units_in;
   logic [2:0] min_tens_ff, min_tens_in;
   logic [3:0] hour_units_ff, hour_units_in;
   logic [1:0] hour_tens_ff, hour_tens_in;

   // Burst register feeding the result channel.
   logic       busy_ff, busy_in;
   logic       single_ff, single_in;
   logic [2:0] beat_ff, beat_in;
   logic [5:0] htens_char_ff, htens_char_in;
   logic [5:0] hunit_char_ff, hunit_char_in;
   logic [5:0] mtens_char_ff, mtens_char_in;
   logic [5:0] munit_char_ff, munit_char_in;

   logic       req_fire;
   logic       rsp_fire;
   logic       last_beat;
   logic       load_full;
   logic       load_single;
   logic [4:0] hour_fold;
   logic [5:0] minute_sat;
   logic [2:0] mt_start;
   logic [4:0] tick_next;

   // Handshake decode.
   assign rsp_valid = busy_ff;
   assign last_beat = single_ff || (beat_ff == BEAT_LAST);
   assign rsp_fire  = busy_ff && !rsp_stall;
   assign req_stall = busy_ff && !(rsp_fire && last_beat);
   assign req_fire  = req_valid && !req_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_column_ff <= 7'd0;
         screen_row_ff    <= 6'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COLUMN: screen_column_ff <= csr_wdata;
            CSR_ROW:    screen_row_ff    <= csr_wdata[5:0];
            default:    screen_column_ff <= screen_column_ff;
         endcase
      end
   end

   // Request decode and time update.
   always_comb begin
      running_in    = running_ff;
      tick_in       = tick_ff;
      sec_units_in  = sec_units_ff;
      sec_tens_in   = sec_tens_ff;
      min_units_in  = min_units_ff;
      min_tens_in   = min_tens_ff;
      hour_units_in = hour_units_ff;
      hour_tens_in  = hour_tens_ff;
      load_full     = 1'b0;
      load_single   = 1'b0;
      tick_next     = tick_ff + 5'd1;

      // Fold the start hour to 1..12 and clamp the start minute.
      hour_fold = req_data.hour_in;
      if (hour_fold >= 5'd24) hour_fold = hour_fold - 5'd24;
      if (hour_fold >= 5'd12) hour_fold = hour_fold - 5'd12;
      if (hour_fold == 5'd0) hour_fold = 5'd12;
      minute_sat = (req_data.minute_in > 6'd59) ? 6'd59 : req_data.minute_in;
      mt_start   = minute_tens(minute_sat);

      if (req_fire) begin
         case (req_data.req_type)
            KIND_START: begin
               if (!running_ff) begin
                  running_in = 1'b1;
                  if (hour_fold > 5'd9) begin
                     hour_tens_in  = HT_ONE;
                     hour_units_in = 4'(hour_fold - 5'd10);
                  end else begin
                     hour_tens_in  = HT_ZERO;
                     hour_units_in = hour_fold[3:0];
                  end
                  min_tens_in  = mt_start;
                  min_units_in = 4'(minute_sat - ({3'b000, mt_start} * 6'd10));
               end
            end
            KIND_STOP: begin
               running_in = 1'b0;
            end
            KIND_TICK: begin
               if (running_ff) begin
                  tick_in = tick_next;
                  if (tick_next == HALF_SEC_TICK) begin
                     load_single = 1'b1;
                  end else if (tick_next == FULL_SEC_TICK) begin
                     load_full = 1'b1;
                     tick_in   = 5'd0;
                     // Seconds, with a long second after each ten.
                     if (sec_units_ff >= 4'd9) begin
                        sec_units_in = 4'd0;
                        tick_in      = LONG_SEC_START;
                        if (sec_tens_ff >= 3'd5) begin
                           sec_tens_in = 3'd0;
                           if (min_units_ff >= 4'd9) begin
                              min_units_in = 4'd0;
                              if (min_tens_ff >= 3'd5) begin
                                 min_tens_in = 3'd0;
                                 // Hour carry, twelve rolls to blank one.
                                 if (hour_units_ff >= 4'd9) begin
                                    hour_tens_in  = HT_ONE;
                                    hour_units_in = 4'd0;
                                 end else begin
                                    hour_units_in = hour_units_ff + 4'd1;
                                 end
                                 if (hour_tens_in == HT_ONE && hour_units_in == 4'd3) begin
                                    hour_tens_in  = HT_BLANK;
                                    hour_units_in = 4'd1;
                                 end
                              end else begin
                                 min_tens_in = min_tens_ff + 3'd1;
                              end
                           end else begin
                              min_units_in = min_units_ff + 4'd1;
                           end
                        end else begin
                           sec_tens_in = sec_tens_ff + 3'd1;
                        end
                     end else begin
                        sec_units_in = sec_units_ff + 4'd1;
                     end
                  end
               end
            end
            default: begin
               running_in = running_ff;
            end
         endcase
      end
   end

   // Burst register next state and character capture.
   always_comb begin
      busy_in       = busy_ff;
      single_in     = single_ff;
      beat_in       = beat_ff;
      htens_char_in = htens_char_ff;
      hunit_char_in = hunit_char_ff;
      mtens_char_in = mtens_char_ff;
      munit_char_in = munit_char_ff;
      if (load_full) begin
         busy_in   = 1'b1;
         single_in = 1'b0;
         beat_in   = BEAT_FIRST;
         case (hour_tens_in)
            HT_ZERO: htens_char_in = CHAR_ZERO;
            HT_ONE:  htens_char_in = CHAR_ONE;
            default: htens_char_in = CHAR_SPACE;
         endcase
         hunit_char_in = CHAR_ZERO + {2'b00, hour_units_in};
         mtens_char_in = CHAR_ZERO + {3'b000, min_tens_in};
         munit_char_in = CHAR_ZERO + {2'b00, min_units_in};
      end else if (load_single) begin
         busy_in   = 1'b1;
         single_in = 1'b1;
         beat_in   = BEAT_COLON;
      end else if (rsp_fire) begin
         if (last_beat) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         tick_ff       <= 5'd0;
         sec_units_ff  <= 4'd0;
         sec_tens_ff   <= 3'd0;
         min_units_ff  <= 4'd0;
         min_tens_ff   <= 3'd0;
         hour_units_ff <= 4'd0;
         hour_tens_ff  <= HT_ZERO;
         busy_ff       <= 1'b0;
         single_ff     <= 1'b0;
         beat_ff       <= BEAT_FIRST;
      end else begin
         running_ff    <= running_in;
         tick_ff       <= tick_in;
         sec_units_ff  <= sec_units_in;
         sec_tens_ff   <= sec_tens_in;
         min_units_ff  <= min_units_in;
         min_tens_ff   <= min_tens_in;
         hour_units_ff <= hour_units_in;
         hour_tens_ff  <= hour_tens_in;
         busy_ff       <= busy_in;
         single_ff     <= single_in;
         beat_ff       <= beat_in;
      end
   end

   // Captured characters need no reset.
   always_ff @(posedge clock) begin
      htens_char_ff <= htens_char_in;
      hunit_char_ff <= hunit_char_in;
      mtens_char_ff <= mtens_char_in;
      munit_char_ff <= munit_char_in;
   end

   // Result fields for the current beat.
   always_comb begin
      rsp_data.char_column = screen_column_ff + {4'b0000, beat_ff};
      rsp_data.char_row    = screen_row_ff;
      rsp_data.last_write  = last_beat;
      case (beat_ff)
         BEAT_FIRST: rsp_data.char_code = htens_char_ff;
         BEAT_HUNIT: rsp_data.char_code = hunit_char_ff;
         BEAT_COLON: rsp_data.char_code = single_ff ? CHAR_SPACE : CHAR_COLON;
         BEAT_MTENS: rsp_data.char_code = mtens_char_ff;
         default:    rsp_data.char_code = munit_char_ff;
      endcase
   end

   // The prescaler skips 19..29; it only reaches 30 at a long second.
   `ASSERT_IMPLY(a_tick_range, clock, reset, 1'b1, tick_ff <= FULL_SEC_TICK || tick_ff >= LONG_SEC_START)
   // Second digits stay decimal.
   `ASSERT_IMPLY(a_sec_digits, clock, reset, 1'b1, sec_units_ff <= 4'd9 && sec_tens_ff <= 3'd5)
   // A blank-colon burst is one write at the colon position.
   `ASSERT_IMPLY(a_single_beat, clock, reset, busy_ff && single_ff, beat_ff == BEAT_COLON)
   // The last write of a burst frees the result side unless a request reloads it.
   `ASSERT_NEXT(a_burst_end, clock, reset, rsp_fire && last_beat && !req_fire, !busy_ff)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tthc_pkg::*;

   // Request type with no meaning; the block must ignore it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Tracks the clock face and holds the character writes it should produce.
   class screen_clock_scoreboard;
      logic [6:0]  column;
      logic [5:0]  row;
      bit          running;
      logic [4:0]  prescale;
      int unsigned sec_units;
      int unsigned sec_tens;
      int unsigned min_units;
      int unsigned min_tens;
      int unsigned hour_units;
      logic [1:0]  hour_tens;

      tthc_rsp_type expected_writes[$];

      int unsigned error_count;
      int unsigned requests_seen;
      int unsigned writes_checked;
      int unsigned blanks_seen;
      int unsigned seconds_seen;
      int unsigned hour_carries;
      int unsigned noon_wraps;

      function new();
         column     = '0;
         row        = '0;
         running    = 1'b0;
         prescale   = '0;
         sec_units  = 0;
         sec_tens   = 0;
         min_units  = 0;
         min_tens   = 0;
         hour_units = 0;
         hour_tens  = HT_ZERO;
      endfunction

      function void set_register(logic index, logic [6:0] value);
         if (index == CSR_COLUMN) begin
            column = value;
         end else begin
            row = value[5:0];
         end
      endfunction

      function void push_write(logic [2:0] offset, logic [5:0] code, logic last);
         tthc_rsp_type w;
         w.char_column = column + {4'b0, offset};
         w.char_row    = row;
         w.char_code   = code;
         w.last_write  = last;
         expected_writes.push_back(w);
      endfunction

      // One second passes; every tenth second the next one is two ticks longer.
      function void advance_second();
         sec_units++;
         if (sec_units <= 9) return;
         sec_units = 0;
         prescale  = prescale - 5'd2;
         sec_tens++;
         if (sec_tens < 6) return;
         sec_tens = 0;
         min_units++;
         if (min_units <= 9) return;
         min_units = 0;
         min_tens++;
         if (min_tens < 6) return;
         min_tens = 0;
         hour_carries++;
         hour_units++;
         if (hour_units > 9) begin
            hour_tens  = HT_ONE;
            hour_units = 0;
         end
         if (hour_tens == HT_ONE && hour_units == 3) begin
            hour_tens  = HT_BLANK;
            hour_units = 1;
            noon_wraps++;
         end
      endfunction

      function void note_request(tthc_req_type item);
         int unsigned h;
         int unsigned m;
         logic [5:0]  tens_code;
         requests_seen++;
         case (item.req_type)
            KIND_START: begin
               // A start while running keeps the current time.
               if (!running) begin
                  running = 1'b1;
                  h = item.hour_in;
                  if (h >= 24) h -= 24;
                  if (h >= 12) h -= 12;
                  if (h == 0) h = 12;
                  if (h > 9) begin
                     hour_tens  = HT_ONE;
                     hour_units = h - 10;
                  end else begin
                     hour_tens  = HT_ZERO;
                     hour_units = h;
                  end
                  m = item.minute_in;
                  if (m > 59) m = 59;
                  min_tens  = m / 10;
                  min_units = m % 10;
               end
            end
            KIND_STOP: begin
               running = 1'b0;
            end
            KIND_TICK: begin
               if (running) begin
                  prescale = prescale + 5'd1;
                  if (prescale == HALF_SEC_TICK) begin
                     blanks_seen++;
                     push_write(BEAT_COLON, CHAR_SPACE, 1'b1);
                  end else if (prescale == FULL_SEC_TICK) begin
                     seconds_seen++;
                     prescale = '0;
                     advance_second();
                     if (hour_tens == HT_ZERO) tens_code = CHAR_ZERO;
                     else if (hour_tens == HT_ONE) tens_code = CHAR_ONE;
                     else tens_code = CHAR_SPACE;
                     push_write(BEAT_FIRST, tens_code, 1'b0);
                     push_write(BEAT_HUNIT, CHAR_ZERO + 6'(hour_units), 1'b0);
                     push_write(BEAT_COLON, CHAR_COLON, 1'b0);
                     push_write(BEAT_MTENS, CHAR_ZERO + 6'(min_tens), 1'b0);
                     push_write(BEAT_LAST, CHAR_ZERO + 6'(min_units), 1'b1);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void check_write(tthc_rsp_type actual);
         tthc_rsp_type want;
         if (expected_writes.size() == 0) begin
            $error("character write with none expected: column %0d row %0d code %0d",
                   actual.char_column, actual.char_row, actual.char_code);
            error_count++;
            return;
         end
         want = expected_writes.pop_front();
         writes_checked++;
         if (actual.char_column !== want.char_column) begin
            $error("char_column: expected %0d, actual %0d", want.char_column,
                   actual.char_column);
            error_count++;
         end
         if (actual.char_row !== want.char_row) begin
            $error("char_row: expected %0d, actual %0d", want.char_row, actual.char_row);
            error_count++;
         end
         if (actual.char_code !== want.char_code) begin
            $error("char_code: expected %0d, actual %0d", want.char_code,
                   actual.char_code);
            error_count++;
         end
         if (actual.last_write !== want.last_write) begin
            $error("last_write: expected %0d, actual %0d", want.last_write,
                   actual.last_write);
            error_count++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   tthc_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   tthc_rsp_type rsp_data;
   logic         csr_write;
   logic         csr_index;
   logic [6:0]   csr_wdata;

   screen_clock_scoreboard sb;
   bit quiet_tail;
   bit long_hold_done;

   twelve_hour_tick_clock u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest legal pace.
   initial begin
      #(30_000_000);
      $display("status: fail");
      $finish;
   end

   // Every transfer is seen here; requests are noted before results are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_write(rsp_data);
      end
   end

   // Result side: random stall bursts, one long hold-off, none in the tail.
   initial begin
      rsp_stall = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!long_hold_done && sb.writes_checked >= 20 && rsp_valid) begin
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request, possibly after a gap, and return at its transfer.
   task automatic send_request(input logic [1:0] kind, input logic [4:0] hour,
                               input logic [5:0] minute);
      tthc_req_type item;
      item.req_type  = kind;
      item.hour_in   = hour;
      item.minute_in = minute;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering requests and let every pending character write drain.
   // The task waits for a clock edge first so the last transfer has been noted.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_writes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_position(input logic [6:0] column, input logic [6:0] row_data);
      csr_write <= 1'b1;
      csr_index <= CSR_COLUMN;
      csr_wdata <= column;
      @(posedge clock);
      sb.set_register(CSR_COLUMN, column);
      csr_index <= CSR_ROW;
      csr_wdata <= row_data;
      @(posedge clock);
      sb.set_register(CSR_ROW, row_data);
      csr_write <= 1'b0;
   endtask

   // A restart with a fresh time now and then, stray items, then a run of ticks.
   task automatic run_round();
      logic [4:0] hour;
      logic [5:0] minute;
      if ($urandom_range(0, 2) == 0) begin
         send_request(KIND_STOP, 5'($urandom), 6'($urandom));
         // Ticks while stopped must leave the prescaler alone.
         repeat ($urandom_range(0, 3)) send_request(KIND_TICK, 5'($urandom), 6'($urandom));
         if ($urandom_range(0, 7) == 0) send_request(KIND_UNUSED, 5'($urandom), 6'($urandom));
         if ($urandom_range(0, 1) == 0) begin
            // Times just before an hour carry.
            case ($urandom_range(0, 7))
               0: hour = 5'd0;
               1: hour = 5'd9;
               2: hour = 5'd11;
               3: hour = 5'd12;
               4: hour = 5'd21;
               5: hour = 5'd23;
               6: hour = 5'd24;
               default: hour = 5'd31;
            endcase
            minute = 6'($urandom_range(58, 63));
         end else begin
            hour   = 5'($urandom);
            minute = 6'($urandom);
         end
         send_request(KIND_START, hour, minute);
      end else if ($urandom_range(0, 9) == 0) begin
         // A start while running, or an unused type, must change nothing.
         send_request($urandom_range(0, 1) ? KIND_START : KIND_UNUSED,
                      5'($urandom), 6'($urandom));
      end
      repeat ($urandom_range(1, 60)) send_request(KIND_TICK, 5'($urandom), 6'($urandom));
   endtask

   initial begin
      sb             = new();
      quiet_tail     = 1'b0;
      long_hold_done = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write      = 1'b0;
      csr_index      = CSR_COLUMN;
      csr_wdata      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         wait_for_idle();
         case (phase)
            0: set_position(7'd0, 7'd0);
            1: set_position(7'd79, 7'd49);
            2: set_position(7'd127, 7'd127);
            default: set_position(7'($urandom), 7'($urandom));
         endcase

         if (phase == 0) begin
            // Items ignored while stopped, then one full second at 12:59.
            send_request(KIND_TICK, 5'd31, 6'd63);
            send_request(KIND_STOP, 5'd0, 6'd0);
            send_request(KIND_UNUSED, 5'd0, 6'd0);
            send_request(KIND_START, 5'd0, 6'd63);
            send_request(KIND_START, 5'd5, 6'd5);
            repeat (18) send_request(KIND_TICK, 5'd0, 6'd0);
            send_request(KIND_STOP, 5'd0, 6'd0);
            send_request(KIND_START, 5'd31, 6'd0);
         end

         for (int round = 0; round < 2; round++) begin
            if (phase == 3 && round >= 1) quiet_tail = 1'b1;
            run_round();
         end
      end

      wait_for_idle();
      $display("covered %0d requests and %0d character writes (%0d colon blanks, %0d seconds)",
               sb.requests_seen, sb.writes_checked, sb.blanks_seen, sb.seconds_seen);
      $display("hour carries %0d, of which %0d from 12 to 1, over four screen positions",
               sb.hour_carries, sb.noon_wraps);
      if (sb.error_count == 0 && sb.expected_writes.size() == 0) begin
         $display("status: pass");
      end else begin
         if (sb.expected_writes.size() != 0)
            $error("%0d character writes never arrived", sb.expected_writes.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
